/* hdl/mspfrp_pkg.sv */
package mspfrp_pkg;

	// Fixed field widths
	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned LEN_W       = 11;
	localparam int unsigned POFF_W      = 10;
	localparam int unsigned CMD_W       = 16;
	localparam int unsigned ADDR_W      = 3;
	localparam int unsigned TDATA_W     = 64;
	localparam int unsigned TUSER_W     = 2;

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_LEN = LEN_W'(MAX_PAYLOAD);

	// Register reset values
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 11'd1024;
	localparam logic [7:0]       TUNNEL_RST  = 8'd255;

	// Register index as seen on paddr[2]
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_TUNNEL  = 1'b1;

	// Result kind
	localparam logic [1:0] EV_IGNORED  = 2'd0;
	localparam logic [1:0] EV_ACCEPT   = 2'd1;
	localparam logic [1:0] EV_COMPLETE = 2'd2;
	localparam logic [1:0] EV_DROP     = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LONG   = 2'd1;
	localparam logic [1:0] ERR_HEADER = 2'd2;
	localparam logic [1:0] ERR_SUM    = 2'd3;

	// Frame versions
	localparam logic [1:0] VER_V1     = 2'd0;
	localparam logic [1:0] VER_TUNNEL = 2'd1;
	localparam logic [1:0] VER_V2     = 2'd2;

	// Protocol bytes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CRC_POLY  = 8'hD5;
	localparam logic [7:0] TUNNEL_MIN_SIZE = 8'd6;

	typedef struct packed {
		logic [LEN_W-1:0] max_payload_length;
		logic [7:0]       tunnel_command_id;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0]  payload_length;
		logic [7:0]        frame_flags;
		logic [CMD_W-1:0]  command_code;
		logic              is_reply;
		logic [1:0]        frame_version;
		logic [POFF_W-1:0] payload_offset;
		logic [7:0]        payload_byte;
		logic              payload_valid;
		logic              error_first;
		logic [1:0]        error_code;
		logic [1:0]        event_res;
	} res_t;

	// CRC-8/DVB-S2 over one byte, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* hdl/mspfrp_regs.sv */
module mspfrp_regs import mspfrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_length <= MAX_LEN_RST;
			cfg_q.tunnel_command_id  <= TUNNEL_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_LEN: cfg_q.max_payload_length <= pwdata[LEN_W-1:0];
				REG_TUNNEL:  cfg_q.tunnel_command_id  <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MAX_LEN: prdata = {{(32-LEN_W){1'b0}}, cfg_q.max_payload_length};
			REG_TUNNEL:  prdata = {24'd0, cfg_q.tunnel_command_id};
			default:     prdata = '0;
		endcase
	end

endmodule

/* hdl/mspfrp_parser.sv */
module mspfrp_parser import mspfrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output res_t       res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_HDR_M, PH_HDR_X, PH_HDR_V1, PH_PAY_V1, PH_SUM_V1,
		PH_HDR_T, PH_PAY_T, PH_SUM_T, PH_HDR_N, PH_PAY_N, PH_SUM_N
	} phase_t;

	phase_t           phase_q, phase_nx;
	logic [LEN_W-1:0] off_q, off_nx, off_inc;
	logic [7:0]       hdr_q [7];
	logic [7:0]       hdr_nx [7];
	logic [7:0]       xor_q, xor_nx, crc_q, crc_nx, crc_b;
	logic [1:0]       ver_q, ver_nx;
	logic             rep_q, rep_nx;
	logic [CMD_W-1:0] cmd_q, cmd_nx;
	logic [7:0]       flg_q, flg_nx;
	logic [LEN_W-1:0] len_q, len_nx, limit;
	logic [1:0]       lerr_q, lerr_nx;

	// begin-payload request
	logic             bp_go;
	logic [CMD_W-1:0] bp_cmd;
	logic [7:0]       bp_flg;
	logic [15:0]      bp_len;
	phase_t           bp_pay, bp_sum;

	logic       hdr_wr, emit, drop, keep_err, done;
	logic [1:0] dcode;

	assign off_inc = off_q + LEN_W'(1);
	assign crc_b   = crc8_step(crc_q, rx_byte);
	assign limit   = (cfg.max_payload_length < MAX_PAYLOAD_LEN) ?
			cfg.max_payload_length : MAX_PAYLOAD_LEN;

	always_comb begin
		phase_nx = phase_q;
		off_nx   = off_q;
		xor_nx   = xor_q;
		crc_nx   = crc_q;
		ver_nx   = ver_q;
		rep_nx   = rep_q;
		cmd_nx   = cmd_q;
		flg_nx   = flg_q;
		len_nx   = len_q;
		lerr_nx  = lerr_q;
		hdr_nx   = hdr_q;
		hdr_wr   = 1'b0;
		emit     = 1'b0;
		drop     = 1'b0;
		keep_err = 1'b0;
		done     = 1'b0;
		dcode    = ERR_NONE;
		bp_go    = 1'b0;
		bp_cmd   = '0;
		bp_flg   = '0;
		bp_len   = '0;
		bp_pay   = PH_PAY_V1;
		bp_sum   = PH_SUM_V1;
		res      = '0;
		res.event_res = EV_ACCEPT;

		// header bytes land at the current offset
		if (phase_q == PH_HDR_V1 || phase_q == PH_HDR_T || phase_q == PH_HDR_N) begin
			hdr_wr = 1'b1;
			hdr_nx[off_q[2:0]] = rx_byte;
			off_nx = off_inc;
		end

		unique case (phase_q)
			PH_IDLE: begin
				if (rx_byte != CH_DOLLAR) begin
					res.event_res = EV_IGNORED;
					keep_err = 1'b1;
				end else begin
					phase_nx = PH_START;
				end
			end
			PH_START: begin
				off_nx = '0;
				xor_nx = '0;
				crc_nx = '0;
				if (rx_byte == CH_M) begin
					ver_nx = VER_V1;
					phase_nx = PH_HDR_M;
				end else if (rx_byte == CH_X) begin
					ver_nx = VER_V2;
					phase_nx = PH_HDR_X;
				end else begin
					drop = 1'b1;
					dcode = ERR_HEADER;
				end
			end
			PH_HDR_M, PH_HDR_X: begin
				if (rx_byte == CH_LT || rx_byte == CH_GT) begin
					rep_nx = (rx_byte == CH_GT);
					phase_nx = (phase_q == PH_HDR_M) ? PH_HDR_V1 : PH_HDR_N;
				end else begin
					drop = 1'b1;
					dcode = ERR_HEADER;
				end
			end
			PH_HDR_V1: begin
				xor_nx = xor_q ^ rx_byte;
				if (off_q == LEN_W'(1)) begin
					if (hdr_nx[1] == cfg.tunnel_command_id) begin
						if (hdr_nx[0] < TUNNEL_MIN_SIZE) begin
							drop = 1'b1;
							dcode = ERR_HEADER;
						end else begin
							ver_nx = VER_TUNNEL;
							phase_nx = PH_HDR_T;
						end
					end else begin
						bp_go  = 1'b1;
						bp_cmd = {8'd0, hdr_nx[1]};
						bp_len = {8'd0, hdr_nx[0]};
					end
				end
			end
			PH_PAY_V1: begin
				xor_nx = xor_q ^ rx_byte;
				emit = 1'b1;
			end
			PH_SUM_V1: begin
				if (xor_q != rx_byte) begin
					drop = 1'b1;
					dcode = ERR_SUM;
				end else begin
					done = 1'b1;
				end
			end
			PH_HDR_T: begin
				xor_nx = xor_q ^ rx_byte;
				crc_nx = crc_b;
				if (off_q == LEN_W'(6)) begin
					bp_go  = 1'b1;
					bp_cmd = {hdr_nx[4], hdr_nx[3]};
					bp_flg = hdr_nx[2];
					bp_len = {hdr_nx[6], hdr_nx[5]};
					bp_pay = PH_PAY_T;
					bp_sum = PH_SUM_T;
				end
			end
			PH_PAY_T: begin
				xor_nx = xor_q ^ rx_byte;
				crc_nx = crc_b;
				emit = 1'b1;
			end
			PH_SUM_T: begin
				xor_nx = xor_q ^ rx_byte;
				if (crc_q != rx_byte) begin
					drop = 1'b1;
					dcode = ERR_SUM;
				end else begin
					phase_nx = PH_SUM_V1;
				end
			end
			PH_HDR_N: begin
				crc_nx = crc_b;
				if (off_q == LEN_W'(4)) begin
					bp_go  = 1'b1;
					bp_cmd = {hdr_nx[2], hdr_nx[1]};
					bp_flg = hdr_nx[0];
					bp_len = {hdr_nx[4], hdr_nx[3]};
					bp_pay = PH_PAY_N;
					bp_sum = PH_SUM_N;
				end
			end
			PH_PAY_N: begin
				crc_nx = crc_b;
				emit = 1'b1;
			end
			PH_SUM_N: begin
				if (crc_q != rx_byte) begin
					drop = 1'b1;
					dcode = ERR_SUM;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				phase_nx = PH_IDLE;
				res.event_res = EV_IGNORED;
			end
		endcase

		// header complete: check length, then enter payload or go straight to the sum
		if (bp_go) begin
			if (bp_len > {5'd0, limit}) begin
				drop = 1'b1;
				dcode = ERR_LONG;
			end else begin
				cmd_nx = bp_cmd;
				flg_nx = bp_flg;
				len_nx = bp_len[LEN_W-1:0];
				off_nx = '0;
				phase_nx = (bp_len != 16'd0) ? bp_pay : bp_sum;
			end
		end

		if (emit) begin
			res.payload_valid  = 1'b1;
			res.payload_byte   = rx_byte;
			res.payload_offset = off_q[POFF_W-1:0];
			off_nx = off_inc;
			if (off_inc == len_q) begin
				unique case (phase_q)
					PH_PAY_V1: phase_nx = PH_SUM_V1;
					PH_PAY_T:  phase_nx = PH_SUM_T;
					PH_PAY_N:  phase_nx = PH_SUM_N;
					default:   phase_nx = phase_q;
				endcase
			end
		end

		if (done) begin
			res.event_res      = EV_COMPLETE;
			res.frame_version  = ver_q;
			res.is_reply       = rep_q;
			res.command_code   = cmd_q;
			res.frame_flags    = (ver_q == VER_V1) ? 8'd0 : flg_q;
			res.payload_length = len_q;
			phase_nx = PH_IDLE;
		end

		if (drop) begin
			res.event_res   = EV_DROP;
			res.error_code  = dcode;
			res.error_first = (dcode != lerr_q);
			lerr_nx  = dcode;
			phase_nx = PH_IDLE;
		end else if (!keep_err) begin
			lerr_nx = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			off_q   <= '0;
			xor_q   <= '0;
			crc_q   <= '0;
			ver_q   <= VER_V1;
			rep_q   <= 1'b0;
			cmd_q   <= '0;
			flg_q   <= '0;
			len_q   <= '0;
			lerr_q  <= ERR_NONE;
			for (int i = 0; i < 7; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_nx;
			off_q   <= off_nx;
			xor_q   <= xor_nx;
			crc_q   <= crc_nx;
			ver_q   <= ver_nx;
			rep_q   <= rep_nx;
			cmd_q   <= cmd_nx;
			flg_q   <= flg_nx;
			len_q   <= len_nx;
			lerr_q  <= lerr_nx;
			if (hdr_wr) begin
				hdr_q <= hdr_nx;
			end
		end
	end

endmodule

/* hdl/msp_frame_receive_parser_core.sv */
// MSP frame receive parser. Feed one received serial byte per input beat; every
// byte yields exactly one result beat telling whether it was ignored outside a
// frame, accepted, completed a packet or dropped the frame. Frames in MSP v1 ('$M'),
// v2 tunnelled in v1 (v1 command equal to tunnel_command_id) and native v2 ('$X')
// are recognized; the v1 XOR sum and the CRC-8/DVB-S2 (poly 0xD5) are checked
// on the fly. Payload bytes are not buffered: each comes out with its offset on
// its own result beat, and command, flags, length, version and direction appear
// on the beat of the final checksum byte. A dropped frame reports why (too long,
// bad header byte, bad checksum) and error_first flags a change of error kind.
// Throughput is one byte per clock while m_tready does not stall the output: the
// byte is held in an input register, the parser state advances through
// combinational logic, and the result goes into an output register. The input
// side keeps accepting while a result waits for m_tready, until both registers
// are full. Registers (APB, 32-bit): 0x0 max_payload_length (reset 1024,
// effective limit is min of this and 1024), 0x4 tunnel_command_id (reset 255).
// Write them only while no frame bytes are in flight.
module msp_frame_receive_parser_core import mspfrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// byte stream in
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	// result stream out
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [1:0] error_code, [2] error_first,
	                                      // [3] payload_valid, [11:4] payload_byte,
	                                      // [21:12] payload_offset,
	                                      // [23:22] frame_version, [24] is_reply,
	                                      // [40:25] command_code, [48:41] frame_flags,
	                                      // [59:49] payload_length, [63:60] zero
	output logic [TUSER_W-1:0] m_tuser,   // [1:0] event_res
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t       cfg;
	res_t       res, res_s2;
	logic [7:0] rx_byte_s1;
	logic       vld_s1, vld_s2;
	logic       adv;

	mspfrp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Advance the held byte through the parser when the output slot frees up.
	assign adv      = vld_s1 & (~vld_s2 | m_tready);
	assign s_tready = ~vld_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	// Parser state steps only on the cycle its result is captured.
	mspfrp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.rx_byte(rx_byte_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.event_res;
	assign m_tdata  = {4'd0,
			res_s2.payload_length, res_s2.frame_flags, res_s2.command_code,
			res_s2.is_reply, res_s2.frame_version, res_s2.payload_offset,
			res_s2.payload_byte, res_s2.payload_valid, res_s2.error_first,
			res_s2.error_code};

endmodule

/* hdl/mspfrp_checker.sv */
module mspfrp_checker import mspfrp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [TUSER_W-1:0] m_tuser
);

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Error fields only on a drop, and a drop always carries a code.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == EV_DROP) == (m_tdata[1:0] != ERR_NONE)) &&
			(m_tuser == EV_DROP || m_tdata[2] == 1'b0))
		else $error("error fields disagree with event");

	// Payload bytes only on accepted bytes.
	a_pay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tuser == EV_ACCEPT)
		else $error("payload byte on a non-accept beat");

	// Packet fields stay zero outside a completion.
	a_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_COMPLETE |-> m_tdata[59:22] == '0)
		else $error("packet fields set outside completion");

	// A packet is never longer than the hard limit.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_COMPLETE |-> m_tdata[59:49] <= MAX_PAYLOAD_LEN)
		else $error("completed length over limit");

endmodule

bind msp_frame_receive_parser_core mspfrp_checker u_mspfrp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
